// ===== design/cdq_pkg.sv =====
// Shared constants, codes and types for the circular deque.
package cdq_pkg;

  // Storage geometry
  localparam int DEPTH  = 16;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int WORD_W = 32;
  localparam int CAP_W  = 5;
  localparam int OCC_W  = 5;

  // Capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes
  typedef enum logic [1:0] {
    MODE_PUSH_FRONT = 2'd0,
    MODE_PUSH_BACK  = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_OVER  = 2'd1,
    ST_UNDER = 2'd2
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic exec;   // carry out the accepted item
    logic clear;  // load capacity and empty the deque
  } cdq_cmd_t;

endpackage

// ===== design/cdq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/cdq_ctrl.sv =====
// Controller state machine for the circular deque.
module cdq_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic             cfg_we,
  output logic             busy,
  output logic             done,
  output cdq_pkg::cdq_cmd_t cmd
);
  import cdq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_RESP = 3'b100
  } state_t;

  state_t state, state_next;

  // Next-state logic
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_READ;
        end
      end
      S_READ:  state_next = S_RESP;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Handshake and commands
  assign busy      = (state != S_IDLE);
  assign done      = (state == S_RESP);
  assign cmd.exec  = start && (state == S_IDLE);
  assign cmd.clear = cfg_we;

endmodule

// ===== design/cdq_dp.sv =====
// Datapath of the circular deque: pointers, count, capacity and slot store.
module cdq_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  cdq_pkg::cdq_cmd_t                   cmd,
  input  logic [cdq_pkg::CAP_W-1:0]           cfg_data,
  input  logic [1:0]                          mode,
  input  logic signed [cdq_pkg::WORD_W-1:0]   value,
  output logic [1:0]                          status,
  output logic signed [cdq_pkg::WORD_W-1:0]   front_value,
  output logic signed [cdq_pkg::WORD_W-1:0]   back_value,
  output logic [cdq_pkg::OCC_W-1:0]           occupancy
);
  import cdq_pkg::*;

  logic [CAP_W-1:0]  capacity;
  logic [IDX_W-1:0]  head, head_next;
  logic [IDX_W-1:0]  tail, tail_next;
  logic [CNT_W-1:0]  count, count_next;
  status_t           st_reg, st_next;
  logic [CNT_W-1:0]  cap_live;
  logic [IDX_W-1:0]  cap_last;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] front_rd, back_rd;

  // Effective capacity: zero acts as one, clamp to the store depth
  always_comb begin
    if (capacity == '0) begin
      cap_live = CNT_W'(1);
    end else if (32'(capacity) > 32'(DEPTH)) begin
      cap_live = CNT_W'(DEPTH);
    end else begin
      cap_live = CNT_W'(capacity);
    end
  end

  assign cap_last = IDX_W'(cap_live - CNT_W'(1));

  // Operation decode and pointer update
  always_comb begin
    head_next  = head;
    tail_next  = tail;
    count_next = count;
    st_next    = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = head;
    case (mode_t'(mode))
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (count >= cap_live) begin
          st_next = ST_OVER;
        end else if (count == '0) begin
          head_next  = '0;
          tail_next  = '0;
          wr_en      = 1'b1;
          wr_addr    = '0;
          count_next = CNT_W'(1);
        end else if (mode_t'(mode) == MODE_PUSH_FRONT) begin
          head_next  = (head == '0) ? cap_last : head - IDX_W'(1);
          wr_en      = 1'b1;
          wr_addr    = head_next;
          count_next = count + CNT_W'(1);
        end else begin
          tail_next  = ((CNT_W'(tail) + CNT_W'(1)) >= cap_live) ? '0 : tail + IDX_W'(1);
          wr_en      = 1'b1;
          wr_addr    = tail_next;
          count_next = count + CNT_W'(1);
        end
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (count == '0) begin
          st_next = ST_UNDER;
        end else if (count == CNT_W'(1)) begin
          head_next  = '0;
          tail_next  = '0;
          count_next = '0;
        end else if (mode_t'(mode) == MODE_POP_FRONT) begin
          head_next  = ((CNT_W'(head) + CNT_W'(1)) >= cap_live) ? '0 : head + IDX_W'(1);
          count_next = count - CNT_W'(1);
        end else begin
          tail_next  = (tail == '0) ? cap_last : tail - IDX_W'(1);
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        st_next = ST_DONE;
      end
    endcase
  end

  // Pointer, count and capacity registers
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else if (cmd.clear) begin
      capacity <= cfg_data;
      head     <= '0;
      tail     <= '0;
      count    <= '0;
    end else if (cmd.exec) begin
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Status of the last item
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      st_reg <= st_next;
    end
  end

  // Two copies of the slot store, one read port each for front and back
  cdq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_front (
    .clk   (clk),
    .we    (cmd.exec && wr_en),
    .waddr (wr_addr),
    .wdata (value),
    .raddr (head),
    .rdata (front_rd)
  );

  cdq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram_back (
    .clk   (clk),
    .we    (cmd.exec && wr_en),
    .waddr (wr_addr),
    .wdata (value),
    .raddr (tail),
    .rdata (back_rd)
  );

  // Result fields, -1 when empty
  assign status      = st_reg;
  assign front_value = (count != '0) ? $signed(front_rd) : -WORD_W'(1);
  assign back_value  = (count != '0) ? $signed(back_rd)  : -WORD_W'(1);
  assign occupancy   = OCC_W'(count);

endmodule

// ===== design/circular_deque.sv =====
// Circular deque of signed 32-bit words: top level.
// An item is taken when start is high and busy is low; its result is shown
// with a one-cycle done strobe in state S_RESP, which follows state S_READ.
// A new item is taken only once the last is done, since the registered read of
// the slot store follows the pointer update. The receiver cannot stall.
// Reset empties the deque and sets capacity to 16; slot contents are not cleared.
module circular_deque (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cfg_we,
  input  logic [cdq_pkg::CAP_W-1:0]         cfg_data,
  input  logic [1:0]                        mode,
  input  logic signed [cdq_pkg::WORD_W-1:0] value,
  output logic                              done,
  output logic [1:0]                        status,
  output logic signed [cdq_pkg::WORD_W-1:0] front_value,
  output logic signed [cdq_pkg::WORD_W-1:0] back_value,
  output logic [cdq_pkg::OCC_W-1:0]         occupancy
);
  import cdq_pkg::*;

  cdq_cmd_t cmd;

  // Sequencing
  cdq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .cfg_we (cfg_we),
    .busy   (busy),
    .done   (done),
    .cmd    (cmd)
  );

  // Storage and pointer arithmetic
  cdq_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_data    (cfg_data),
    .mode        (mode),
    .value       (value),
    .status      (status),
    .front_value (front_value),
    .back_value  (back_value),
    .occupancy   (occupancy)
  );

endmodule
